[sv/gdd_pkg.sv]
`default_nettype none

package gdd_pkg;

  localparam int unsigned CoeffWidthDef = 64;
  localparam int unsigned MaxDigitsDef  = 64;

  // fixed payload widths of the channels
  localparam int unsigned FieldW   = 64;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOG_MODULUS   = 2'd0,
    CFG_LOG_DIGIT     = 2'd1,
    CFG_NUM_DIGITS    = 2'd2,
    CFG_SIGNED_DIGITS = 2'd3
  } cfg_reg_e;

  localparam logic [6:0] LogModulusRst   = 7'd64;
  localparam logic [5:0] LogDigitRst     = 6'd8;
  localparam logic [6:0] NumDigitsRst    = 7'd8;
  localparam logic       SignedDigitsRst = 1'b1;

endpackage

`default_nettype wire

[sv/gdd_coeff_if.sv]
`default_nettype none

interface gdd_coeff_if
  import gdd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FieldW-1:0] coeff;

  modport source (output valid, output coeff, input ready);
  modport sink (input valid, input coeff, output ready);
endinterface

`default_nettype wire

[sv/gdd_digit_if.sv]
`default_nettype none

interface gdd_digit_if
  import gdd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FieldW-1:0] digit;
  logic [IdxW-1:0]   digit_index;
  logic              last_digit;

  modport source (output valid, output digit, output digit_index, output last_digit,
                  input ready);
  modport sink (input valid, input digit, input digit_index, input last_digit,
                output ready);
endinterface

`default_nettype wire

[sv/gadget_digit_decomposition_unit.sv]
// pipeline: a coefficient passes through stage 1, stage 2, stage 3, the digit generator and
// the output register; one digit per cycle from the digit generator into the output register
// while the output is not stalled; a coefficient yields as many digits as the configured
// digit count, at most MAX_DIGITS (none at digit width 0); coefficients may enter back to back
// reset: asynchronous active low; clears all valid bits, config returns to 64/8/8/signed
`default_nettype none

module gadget_digit_decomposition_unit
  import gdd_pkg::*;
#(
  parameter int unsigned COEFF_WIDTH = CoeffWidthDef,
  parameter int unsigned MAX_DIGITS  = MaxDigitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  gdd_coeff_if.sink                in_i,
  gdd_digit_if.source              out_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned W         = COEFF_WIDTH;
  localparam logic [6:0]  WidthCode = 7'(W);
  localparam logic [6:0]  MaxNd     = 7'(MAX_DIGITS);

  // configuration registers
  logic [6:0] mod_bits_q;
  logic [5:0] digit_bits_q;
  logic [6:0] digit_cnt_q;
  logic       signed_digits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_bits_q      <= LogModulusRst;
      digit_bits_q    <= LogDigitRst;
      digit_cnt_q     <= NumDigitsRst;
      signed_digits_q <= SignedDigitsRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_LOG_MODULUS:   mod_bits_q      <= cfg_wdata_i;
        CFG_LOG_DIGIT:     digit_bits_q    <= cfg_wdata_i[5:0];
        CFG_NUM_DIGITS:    digit_cnt_q     <= cfg_wdata_i;
        CFG_SIGNED_DIGITS: signed_digits_q <= cfg_wdata_i[0];
        default:           ;
      endcase
    end
  end

  // effective settings; user must keep them static while items are in flight, unenforced
  logic [6:0]  nd_eff;
  logic [6:0]  lm_eff;
  logic [12:0] total_bits;
  logic        round_en_d, round_en_q;
  logic [5:0]  round_shift_d, round_shift_q;
  logic        no_digits;
  logic        big_digit;

  always_comb begin
    nd_eff        = (digit_cnt_q > MaxNd) ? MaxNd : digit_cnt_q;
    lm_eff        = (mod_bits_q == 7'd0 || mod_bits_q > WidthCode) ? WidthCode
                                                                   : mod_bits_q;
    total_bits    = 13'(nd_eff) * 13'(digit_bits_q);
    round_en_d    = 13'(lm_eff) > total_bits;
    round_shift_d = 6'(lm_eff - total_bits[6:0]);
    no_digits     = (digit_bits_q == 6'd0) || (nd_eff == 7'd0);
    big_digit     = {1'b0, digit_bits_q} >= WidthCode;
  end

  // rounding settings are first used in stage 2, so they are registered here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_en_q    <= 1'b0;
      round_shift_q <= '0;
    end else begin
      round_en_q    <= round_en_d;
      round_shift_q <= round_shift_d;
    end
  end

  // handshake chain
  logic s1_v_q, s2_v_q, s3_v_q, g_v_q, o_v_q;
  logic s1_load, s2_load, s3_load, g_take, g_emit, g_last, out_free;

  assign out_free = !o_v_q || out_o.ready;
  assign g_emit   = g_v_q && out_free;
  assign g_take   = !g_v_q || (g_emit && g_last);
  assign s3_load  = !s3_v_q || g_take;
  assign s2_load  = !s2_v_q || s3_load;
  assign s1_load  = !s1_v_q || s2_load;
  assign in_i.ready = s1_load;

  // stage 1: capture
  logic [W-1:0] s1_coeff_q;
  // stage 2: rounding add with carry kept
  logic [W:0]   s2_sum_q, s2_sum_d, round_add;
  // stage 3: shift out the dropped bits
  logic [W-1:0] s3_val_q, s3_val_d;

  always_comb begin
    round_add = round_en_q ? ((W+1)'(1) << (round_shift_q - 6'd1)) : '0;
    s2_sum_d  = {1'b0, s1_coeff_q} + round_add;
    s3_val_d  = W'(s2_sum_q >> (round_en_q ? round_shift_q : 6'd0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_load) s1_v_q <= in_i.valid && !no_digits;
      if (s2_load) s2_v_q <= s1_v_q;
      if (s3_load) s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && in_i.valid) s1_coeff_q <= in_i.coeff[W-1:0];
    if (s2_load && s1_v_q)     s2_sum_q   <= s2_sum_d;
    if (s3_load && s2_v_q)     s3_val_q   <= s3_val_d;
  end

  // digit generator: one digit per cycle from the running value while the output is not stalled
  logic [W-1:0]    g_cur_q, g_cur_d;
  logic [IdxW-1:0] g_idx_q;
  logic [W-1:0]    dmask, low, low_top, dig;
  logic            neg;

  always_comb begin
    dmask   = big_digit ? '1 : ~({W{1'b1}} << digit_bits_q);
    low     = g_cur_q & dmask;
    low_top = low >> (digit_bits_q - 6'd1);
    neg     = signed_digits_q && ({1'b0, digit_bits_q} <= WidthCode) && low_top[0];
    // low minus base, wrapped to the word
    dig     = neg ? (low | ~dmask) : low;
    g_cur_d = (big_digit ? '0 : (g_cur_q >> digit_bits_q)) + W'(neg);
    g_last  = ({1'b0, g_idx_q} == nd_eff - 7'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (g_take)   g_v_q <= s3_v_q;
      if (out_free) o_v_q <= g_v_q;
    end
  end

  logic [FieldW-1:0] o_digit_q;
  logic [IdxW-1:0]   o_idx_q;
  logic              o_last_q;

  always_ff @(posedge clk_i) begin
    if (g_take && s3_v_q) begin
      g_cur_q <= s3_val_q;
      g_idx_q <= '0;
    end else if (g_emit) begin
      g_cur_q <= g_cur_d;
      g_idx_q <= g_idx_q + 6'd1;
    end
    if (g_emit) begin
      o_digit_q <= FieldW'(dig);
      o_idx_q   <= g_idx_q;
      o_last_q  <= g_last;
    end
  end

  assign out_o.valid       = o_v_q;
  assign out_o.digit       = o_digit_q;
  assign out_o.digit_index = o_idx_q;
  assign out_o.last_digit  = o_last_q;

`ifndef SYNTH
  // a digit that is not the last one keeps the generator busy on the next index
  a_gen_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (g_emit && !g_last && !cfg_we_i) |=> (g_v_q && g_idx_q == $past(g_idx_q) + 6'd1))
    else $error("digit generator lost its place");

  // a new coefficient in the generator starts at the least significant digit
  a_gen_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (g_take && s3_v_q) |=> (g_v_q && g_idx_q == '0))
    else $error("digit generator did not restart at index zero");

  // a stage that cannot hand off keeps its item
  a_s3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_v_q && !g_take) |=> (s3_v_q && $stable(s3_val_q)))
    else $error("stalled stage dropped its item");
`endif

endmodule

`default_nettype wire
